// ----- hdl/deq_pkg.sv -----
// Shared types, codes and sizes for the double-ended queue.
package deq_pkg;

  localparam int CAPACITY     = 256;
  localparam int IDX_W        = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int WORD_W       = 32;
  localparam int ITEM_COUNT_W = 9;

  typedef logic [2:0]               action_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ITEM_COUNT_W-1:0]  item_count_t;

  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_PEEK_FRONT = 3'd4;
  localparam action_t ACT_PEEK_BACK  = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam word_t WORD_EMPTY = '1;

  typedef struct packed {
    logic  we;
    logic  re;
    idx_t  addr;
    word_t wdata;
  } mem_req_t;

  typedef struct packed {
    logic    use_mem;
    word_t   value;
    cnt_t    count;
    status_t status;
  } result_meta_t;

endpackage

// ----- hdl/deq_if.sv -----
// Handshake interfaces for the action and result channels.
interface deq_in_if;
  import deq_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  word_t   value_in;

  modport source(output valid, output action, output value_in, input ready);
  modport sink(input valid, input action, input value_in, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;
  logic        valid;
  logic        ready;
  word_t       value_out;
  item_count_t item_count;
  status_t     status;

  modport source(output valid, output value_out, output item_count, output status,
                 input ready);
  modport sink(input valid, input value_out, input item_count, input status,
               output ready);
endinterface

// ----- hdl/deq_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
module deq_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/deq_ctrl.sv -----
// Front index and count registers, action decode and store addressing.
module deq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  deq_pkg::action_t      action,
  input  deq_pkg::word_t        value_in,
  output deq_pkg::mem_req_t     mem_req,
  output deq_pkg::result_meta_t meta
);
  import deq_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  idx_t               front_r, front_nxt;
  cnt_t               count_r, count_nxt;
  logic               full, empty;
  idx_t               front_dec, front_inc, tail_pos, back_pos;
  logic [SUM_W-1:0]   tail_sum, back_sum;
  mem_req_t           req;
  result_meta_t       res;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IDX_W'(CAPACITY - 1)) ? '0 : front_r + 1'b1;

  assign tail_sum = SUM_W'(front_r) + SUM_W'(count_r);
  assign back_sum = tail_sum - 1'b1;
  assign tail_pos = (tail_sum >= SUM_W'(CAPACITY)) ?
                    IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);
  assign back_pos = (back_sum >= SUM_W'(CAPACITY)) ?
                    IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);

  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    req.we      = 1'b0;
    req.re      = 1'b0;
    req.addr    = front_r;
    req.wdata   = value_in;
    res.use_mem = 1'b0;
    res.value   = '0;
    res.status  = ST_OK;
    unique case (action) inside
      ACT_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
          req.we    = accept;
          req.addr  = front_dec;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          req.we    = accept;
          req.addr  = tail_pos;
        end
      end
      ACT_POP_FRONT, ACT_PEEK_FRONT: begin
        if (empty) begin
          res.value  = WORD_EMPTY;
          res.status = ST_EMPTY;
        end else begin
          res.use_mem = 1'b1;
          req.re      = accept;
          req.addr    = front_r;
          if (action == ACT_POP_FRONT) begin
            front_nxt = front_inc;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      ACT_POP_BACK, ACT_PEEK_BACK: begin
        if (empty) begin
          res.value  = WORD_EMPTY;
          res.status = ST_EMPTY;
        end else begin
          res.use_mem = 1'b1;
          req.re      = accept;
          req.addr    = back_pos;
          if (action == ACT_POP_BACK) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  assign mem_req = req;
  assign meta    = res;

endmodule

// ----- hdl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of signed words.
//
//   Channel  Direction  Payload
//   in_ch    sink       action, value_in
//   out_ch   source     value_out, item_count, status
//
// One item is accepted per cycle unless out_ch stalls; its result passes through the
// store's registered read and the stage-1 metadata register, then the result register.
// Pointer and count updates happen at acceptance, so back-to-back items see each
// other's effects. Reset clears the front index, count and valid flags, not the store.
// While a result waits for out_ch.ready, the pipeline holds and in_ch.ready is low.
module double_ended_queue (
  input logic       clk,
  input logic       rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);
  import deq_pkg::*;

  logic         advance, accept;
  mem_req_t     mem_req;
  result_meta_t meta;
  result_meta_t s1_meta_r;
  logic         s1_valid_r;
  word_t        rdata;
  logic         out_valid_r;
  word_t        out_value_r;
  item_count_t  out_count_r;
  status_t      out_status_r;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .action   (in_ch.action),
    .value_in (in_ch.value_in),
    .mem_req  (mem_req),
    .meta     (meta)
  );

  deq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .re   (mem_req.re),
    .addr (mem_req.addr),
    .wdata(mem_req.wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
    if (advance && s1_valid_r) begin
      out_value_r  <= s1_meta_r.use_mem ? rdata : s1_meta_r.value;
      out_count_r  <= ITEM_COUNT_W'(s1_meta_r.count);
      out_status_r <= s1_meta_r.status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value_out  = out_value_r;
  assign out_ch.item_count = out_count_r;
  assign out_ch.status     = out_status_r;

endmodule

// ----- hdl/deq_chk.sv -----
// Port-level assertions for the double-ended queue and their binding.
module deq_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input deq_pkg::word_t       out_value,
  input deq_pkg::item_count_t out_count,
  input deq_pkg::status_t     out_status
);
  import deq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
      $stable(out_count) && $stable(out_status))
    else $error("Stalled result item changed.");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_value == WORD_EMPTY && out_count == '0)
    else $error("Refused pop or peek did not report an empty deque.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_value == '0 && out_count == ITEM_COUNT_W'(CAPACITY))
    else $error("Dropped push did not report a full deque.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_EMPTY || out_status == ST_FULL)
    else $error("Result item carries an unknown status.");

endmodule

bind double_ended_queue deq_chk u_deq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value_out),
  .out_count (out_ch.item_count),
  .out_status(out_ch.status)
);
